// ===== src/sece_pkg.sv =====
// shared types, codes and constants of the spike event channel encoder
// no dependencies; the exp lookup table is built here at elaboration
package sece_pkg;

  localparam int NUM_CH    = 64;
  localparam int CH_W      = 6;
  localparam int CNT_W     = 7;
  localparam int EXP_SIZE  = 256;
  localparam int EXP_IDX_W = 8;
  localparam int EXP_SPAN  = 16;
  // the exp argument in Q16.16 stays below EXP_SPAN, so index bits sit under this
  localparam int EXP_ARG_W = 16 + $clog2(EXP_SPAN);

  localparam logic signed [63:0] SUM_LIMIT = 64'sh4000_0000_0000_0000;
  localparam logic signed [31:0] VAL_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN   = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_EVENT = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_RATE    = 2'd0,
    MODE_LATENCY = 2'd1,
    MODE_FILTER  = 2'd2,
    MODE_POP     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_CHANS = 3'd1,
    REG_RATE  = 3'd2,
    REG_STIM  = 3'd3,
    REG_LAT   = 3'd4,
    REG_DECAY = 3'd5,
    REG_GAIN  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_FOLD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EV_RD,
    B_EV_WR,
    B_CL_RD,
    B_CL_MUL,
    B_CL_OUT
  } back_state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        event_time;
    logic signed [15:0] channel;
    logic signed [15:0] amplitude;
  } item_t;

  typedef struct packed {
    logic [5:0]         channel_index;
    logic signed [31:0] value;
    logic               last;
  } result_t;

  // queue entry: channel already folded
  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        event_time;
    logic [CH_W-1:0]    ch;
    logic signed [15:0] amplitude;
  } qent_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [CNT_W-1:0] chans;
    logic [31:0] rate_scale;
    logic [31:0] stimulus_time;
    logic [31:0] latency_scale;
    logic [15:0] filter_decay;
    logic [31:0] filter_gain;
  } cfg_t;

  typedef logic [31:0] exp_tab_t [EXP_SIZE];

  // exp(-16k/EXP_SIZE) in Q16.16, via a Q30 taylor series and repeated products
  function automatic exp_tab_t build_exp_table();
    exp_tab_t tab;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] p;
    logic signed [63:0] sum;
    y    = (64'(EXP_SPAN) << 30) / 64'(EXP_SIZE);
    term = 64'd1 << 30;
    sum  = signed'(term);
    for (int n = 1; n < 64; n++) begin
      if (term != 64'd0) begin
        term = ((term * y) >> 30) / 64'(n);
        if (n[0]) sum = sum - signed'(term);
        else sum = sum + signed'(term);
      end
    end
    if (sum < 0) sum = 64'sd0;
    r = unsigned'(sum);
    p = 64'd1 << 30;
    for (int k = 0; k < EXP_SIZE; k++) begin
      tab[k] = 32'((p + 64'd8192) >> 14);
      p = (p * r + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

// ===== src/sece_front.sv =====
// front end: accepts items, drops unknown commands, folds event channels
// modulo the active channel count one bit a cycle; depends on sece_pkg
module sece_front (
  input  logic                     clk,
  input  logic                     rst,
  input  sece_pkg::item_t          item,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [sece_pkg::CNT_W-1:0] ch_count,
  output logic                     push,
  output sece_pkg::qent_t          push_data,
  input  logic                     q_full
);
  import sece_pkg::*;

  front_state_t state, state_next;
  item_t        held;
  logic [15:0]  mag;
  logic [CNT_W-1:0] rem, rem_next;
  logic [3:0]   bit_idx;
  logic [CNT_W-1:0] trial;
  logic [CNT_W-1:0] fold_ch;
  logic         accept;

  assign accept = item_valid && !item_stall;
  assign trial  = {rem[CNT_W-2:0], mag[bit_idx]};

  always_comb begin
    rem_next = (trial >= ch_count) ? trial - ch_count : trial;
  end

  // negative raw channels wrap up from the top
  assign fold_ch = (held.channel[15] && rem != '0) ? ch_count - rem : rem;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          if (item.command == CMD_EVENT) state_next = F_FOLD;
          else if (item.command == CMD_OPEN || item.command == CMD_CLOSE) state_next = F_PUSH;
        end
      end
      F_FOLD: if (bit_idx == 4'd0) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != F_IDLE);
    push       = (state == F_PUSH) && !q_full;
    push_data.command    = held.command;
    push_data.event_time = held.event_time;
    push_data.ch         = fold_ch[CH_W-1:0];
    push_data.amplitude  = held.amplitude;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held    <= item;
      mag     <= item.channel[15] ? 16'(~item.channel + 16'sd1) : 16'(item.channel);
      rem     <= '0;
      bit_idx <= 4'd15;
    end else if (state == F_FOLD) begin
      rem     <= rem_next;
      bit_idx <= bit_idx - 4'd1;
    end
  end

endmodule

// ===== src/sece_queue.sv =====
// short fifo between the front end and the back end
// depends on sece_pkg for the entry type
module sece_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sece_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output sece_pkg::qent_t head,
  output logic            empty
);
  import sece_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  qent_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [LVL_W-1:0] level;

  assign full  = (level == LVL_W'(DEPTH));
  assign empty = (level == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

endmodule

// ===== src/sece_back.sv =====
// back end: per-channel window state in memories, event read-modify-write
// and the close walk that encodes each channel; depends on sece_pkg
module sece_back (
  input  logic                       clk,
  input  logic                       rst,
  input  sece_pkg::cfg_t             cfg,
  input  logic [sece_pkg::CNT_W-1:0] ch_count,
  input  sece_pkg::qent_t            head,
  input  logic                       q_empty,
  output logic                       pop,
  output sece_pkg::result_t          result,
  output logic                       result_valid,
  input  logic                       result_stall
);
  import sece_pkg::*;

  back_state_t state, state_next;

  logic [31:0]        cur_time;
  logic [CH_W-1:0]    cur_ch;
  logic signed [15:0] cur_amp;
  logic [31:0]        win_begin;
  logic [NUM_CH-1:0]  win_vld;
  logic [NUM_CH-1:0]  filt_vld;
  logic [CNT_W-1:0]   filt_dim;
  logic [CH_W-1:0]    idx;

  logic [31:0]        cnt_mem   [NUM_CH];
  logic [31:0]        first_mem [NUM_CH];
  logic signed [63:0] sum_mem   [NUM_CH];
  logic signed [31:0] filt_mem  [NUM_CH];

  logic [CH_W-1:0]    rd_addr;
  logic [31:0]        rd_cnt, rd_first;
  logic signed [63:0] rd_sum;
  logic signed [31:0] rd_filt;
  logic               rd_wv, rd_fv;

  logic signed [48:0] ev_prod;
  logic [31:0]        cnt_eff, cnt_new, first_new;
  logic signed [63:0] sum_old, sum_raw, sum_new;
  logic               ev_we;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_q;
  logic signed [63:0] sum_q;
  logic               lat_seen, lat_neg;
  logic signed [56:0] filt_tot;
  logic signed [31:0] val;
  logic               out_load, last_ch, filt_restart;

  assign last_ch = ({1'b0, idx} == ch_count - 1'b1);
  assign out_load = (state == B_CL_OUT) && (!result_valid || !result_stall);
  assign filt_restart = (cfg.mode == MODE_FILTER) && (filt_dim != ch_count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (head.command == CMD_EVENT && head.event_time >= win_begin) state_next = B_EV_RD;
          else if (head.command == CMD_CLOSE) state_next = B_CL_RD;
        end
      end
      B_EV_RD:  state_next = B_EV_WR;
      B_EV_WR:  state_next = B_IDLE;
      B_CL_RD:  state_next = B_CL_MUL;
      B_CL_MUL: state_next = B_CL_OUT;
      B_CL_OUT: if (out_load) state_next = last_ch ? B_IDLE : B_CL_RD;
      default:  state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop     = (state == B_IDLE) && !q_empty;
    ev_we   = (state == B_EV_WR);
    rd_addr = (state == B_EV_RD) ? cur_ch : idx;
  end

  // event update, entries outside the window read as zero
  always_comb begin
    cnt_eff   = rd_wv ? rd_cnt : 32'd0;
    cnt_new   = (cnt_eff == 32'hFFFF_FFFF) ? cnt_eff : cnt_eff + 32'd1;
    first_new = (!rd_wv || cur_time < rd_first) ? cur_time : rd_first;
    sum_old   = rd_wv ? rd_sum : 64'sd0;
    sum_raw   = sum_old + 64'(ev_prod);
    if (sum_raw > SUM_LIMIT) sum_new = SUM_LIMIT;
    else if (sum_raw < -SUM_LIMIT) sum_new = -SUM_LIMIT;
    else sum_new = sum_raw;
  end

  // one shared multiplier for the close walk
  always_comb begin
    case (cfg.mode)
      MODE_LATENCY: begin
        mul_a = signed'({2'b00, rd_first - cfg.stimulus_time});
        mul_b = signed'({2'b00, cfg.latency_scale});
      end
      MODE_FILTER: begin
        mul_a = 34'(rd_fv ? rd_filt : 32'sd0);
        mul_b = signed'({18'd0, cfg.filter_decay});
      end
      default: begin
        mul_a = signed'({2'b00, rd_wv ? rd_cnt : 32'd0});
        mul_b = signed'({2'b00, cfg.rate_scale});
      end
    endcase
  end

  always_comb begin
    // both terms are signed, arithmetic shifts round toward minus infinity
    filt_tot = 57'(signed'(mul_q[65:16])) + 57'(signed'(sum_q[63:8]));
    case (cfg.mode)
      MODE_LATENCY: begin
        if (!lat_seen) val = 32'sd0;
        else if (lat_neg) val = VAL_MAX;
        else if (mul_q[63:EXP_ARG_W] != '0) val = 32'sd0;
        else val = signed'(EXP_TABLE[mul_q[EXP_ARG_W-1 -: EXP_IDX_W]]);
      end
      MODE_FILTER: begin
        if (filt_tot > 57'(VAL_MAX)) val = VAL_MAX;
        else if (filt_tot < 57'(VAL_MIN)) val = VAL_MIN;
        else val = filt_tot[31:0];
      end
      default: begin
        val = (mul_q[63:0] > 64'h7FFF_FFFF) ? VAL_MAX : mul_q[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      win_begin <= '0;
      win_vld   <= '0;
      filt_vld  <= '0;
      filt_dim  <= '0;
      idx       <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        if (head.command == CMD_OPEN) begin
          win_begin <= head.event_time;
          win_vld   <= '0;
        end
        if (head.command == CMD_CLOSE) begin
          idx <= '0;
          if (filt_restart) begin
            filt_vld <= '0;
            filt_dim <= ch_count;
          end
        end
      end
      if (ev_we) win_vld[cur_ch] <= 1'b1;
      if (out_load) begin
        idx <= idx + 1'b1;
        if (cfg.mode == MODE_FILTER) filt_vld[idx] <= 1'b1;
      end
      if (out_load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_time <= head.event_time;
      cur_ch   <= head.ch;
      cur_amp  <= head.amplitude;
    end
    if (state == B_EV_RD) ev_prod <= cur_amp * signed'({1'b0, cfg.filter_gain});
    if (state == B_CL_MUL) begin
      mul_q    <= mul_a * mul_b;
      sum_q    <= rd_wv ? rd_sum : 64'sd0;
      lat_seen <= rd_wv;
      lat_neg  <= rd_first < cfg.stimulus_time;
    end
    if (out_load) begin
      result.channel_index <= idx;
      result.value         <= val;
      result.last          <= last_ch;
    end
  end

  // window state memories
  always_ff @(posedge clk) begin
    rd_cnt   <= cnt_mem[rd_addr];
    rd_first <= first_mem[rd_addr];
    rd_sum   <= sum_mem[rd_addr];
    rd_filt  <= filt_mem[rd_addr];
    rd_wv    <= win_vld[rd_addr];
    rd_fv    <= filt_vld[rd_addr];
    if (ev_we) begin
      cnt_mem[cur_ch]   <= cnt_new;
      first_mem[cur_ch] <= first_new;
      sum_mem[cur_ch]   <= sum_new;
    end
    if (out_load && cfg.mode == MODE_FILTER) filt_mem[idx] <= val;
  end

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_CL_RD || state == B_CL_MUL || state == B_CL_OUT) |-> ({1'b0, idx} < ch_count))
    else $error("close walk index beyond active channels");

  a_event_marks_seen: assert property (@(posedge clk) disable iff (rst)
    (state == B_EV_WR) |=> win_vld[$past(cur_ch)])
    else $error("event write did not mark channel seen");

  a_last_matches_count: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_ch) |=> (result_valid && result.last && state == B_IDLE))
    else $error("final channel not flagged or walk not finished");

  a_free_slot_loads: assert property (@(posedge clk) disable iff (rst)
    (state == B_CL_OUT && !result_valid) |=> result_valid)
    else $error("free output slot not loaded");

endmodule

// ===== src/spike_event_channel_encoder_unit.sv =====
// spike event channel encoder top level: configuration registers, front end,
// queue and back end. depends on sece_pkg, sece_front, sece_queue, sece_back
// events get a 16-step channel fold in the front end, a read and a write in the back end
// open skips the fold; close walks each channel through B_CL_RD, B_CL_MUL and B_CL_OUT
// throughput is set by the front end for events and opens, by the close walk for closes
// reset is synchronous: control state and per-channel valid bits clear at once
module spike_event_channel_encoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  sece_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_stall,
  output sece_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import sece_pkg::*;

  cfg_t             cfg;
  logic [CNT_W-1:0] ch_count;
  logic             push, q_full, q_empty, pop;
  qent_t            push_data, head;

  assign cfg_ready = 1'b1;

  // zero acts as one, anything above the channel count saturates
  always_comb begin
    if (cfg.chans == '0) ch_count = CNT_W'(1);
    else if (cfg.chans > CNT_W'(NUM_CH)) ch_count = CNT_W'(NUM_CH);
    else ch_count = cfg.chans;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= MODE_RATE;
      cfg.chans         <= CNT_W'(NUM_CH);
      cfg.rate_scale    <= 32'd65536;
      cfg.stimulus_time <= 32'd0;
      cfg.latency_scale <= 32'd65536;
      cfg.filter_decay  <= 16'hFFFF;
      cfg.filter_gain   <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:  cfg.mode          <= cfg_data[1:0];
        REG_CHANS: cfg.chans         <= cfg_data[CNT_W-1:0];
        REG_RATE:  cfg.rate_scale    <= cfg_data;
        REG_STIM:  cfg.stimulus_time <= cfg_data;
        REG_LAT:   cfg.latency_scale <= cfg_data;
        REG_DECAY: cfg.filter_decay  <= cfg_data[15:0];
        REG_GAIN:  cfg.filter_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  sece_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .ch_count   (ch_count),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  sece_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  sece_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .ch_count     (ch_count),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
